>>> src/apf_pkg.sv
// shared types and constants of the articulation point finder
package apf_pkg;

	localparam int APF_MAX_NODES = 64;
	localparam int FIELD_W = 7;
	localparam logic [FIELD_W-1:0] NODE_COUNT_RESET = 7'd64;

	typedef enum logic [1:0] {
		MARK_NONE = 2'd0,
		MARK_SEEN = 2'd1,
		MARK_GONE = 2'd2
	} mark_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_CLR_ADJ,
		OP_ACCEPT,
		OP_EA_RD,
		OP_EA_WR,
		OP_EB_RD,
		OP_EB_WR,
		OP_NCLR,
		OP_ARD,
		OP_AWR,
		OP_OINIT,
		OP_OUTER_RD,
		OP_OUTER_NEXT,
		OP_ROOT,
		OP_SKIP,
		OP_SCAN_RD,
		OP_PUSH1,
		OP_PUSH2,
		OP_BACK,
		OP_POP_RD,
		OP_POP2,
		OP_WALK_END,
		OP_PHASE2,
		OP_LOAD_OUT
	} dp_op_t;

	typedef struct packed {
		logic clr_last;
		logic run;
		logic edge_ok;
		logic outer_done;
		logic rd_none;
		logic scan_end;
		logic row_bit;
		logic has_parent;
		logic phase;
		logic out_busy;
	} dp_status_t;

endpackage

>>> src/apf_if.sv
// valid/ready channel interfaces for edge/run items and summary results
interface apf_in_if;
	logic valid;
	logic ready;
	logic mode;
	logic [apf_pkg::FIELD_W-1:0] node_a;
	logic [apf_pkg::FIELD_W-1:0] node_b;
	modport source(output valid, mode, node_a, node_b, input ready);
	modport sink(input valid, mode, node_a, node_b, output ready);
endinterface

interface apf_out_if;
	logic valid;
	logic ready;
	logic [apf_pkg::FIELD_W-1:0] component_count;
	logic [apf_pkg::FIELD_W-1:0] articulation_count;
	logic [apf_pkg::FIELD_W-1:0] biggest_remaining;
	modport source(output valid, component_count, articulation_count, biggest_remaining,
		input ready);
	modport sink(input valid, component_count, articulation_count, biggest_remaining,
		output ready);
endinterface

>>> src/apf_ram.sv
// generic single write port ram with registered read
module apf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> src/apf_datapath.sv
// datapath: adjacency, node and stack memories, walk registers, result register
module apf_datapath #(
	parameter int MAX_NODES = apf_pkg::APF_MAX_NODES
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wen,
	input  logic [apf_pkg::FIELD_W-1:0] cfg_wdata,
	input  logic                        in_mode,
	input  logic [apf_pkg::FIELD_W-1:0] in_node_a,
	input  logic [apf_pkg::FIELD_W-1:0] in_node_b,
	input  apf_pkg::dp_op_t             op,
	output apf_pkg::dp_status_t         status,
	input  logic                        out_ready,
	output logic                        out_valid,
	output logic [apf_pkg::FIELD_W-1:0] component_count,
	output logic [apf_pkg::FIELD_W-1:0] articulation_count,
	output logic [apf_pkg::FIELD_W-1:0] biggest_remaining
);
	localparam int NW = $clog2(MAX_NODES);
	localparam int TW = $clog2(MAX_NODES + 1);
	localparam logic [MAX_NODES-1:0] ONE_HOT0 = MAX_NODES'(1);
	localparam logic [NW-1:0] LAST_IDX = NW'(MAX_NODES - 1);

	typedef struct packed {
		apf_pkg::mark_t mark;
		logic [TW-1:0]  disc;
		logic [TW-1:0]  low;
		logic [NW-1:0]  par;
		logic           pv;
	} node_t;
	localparam int NODE_W = $bits(node_t);

	logic [apf_pkg::FIELD_W-1:0] node_count_q, a_q, b_q;
	logic [NW-1:0]               k_q, u_q, root_q, par_q, depth_q;
	logic                        phase_q, pv_q, res_valid_q;
	logic [MAX_NODES-1:0]        flags_q, row_q;
	logic [TW-1:0]               i_q, v_q, timer_q, disc_q, low_q;
	logic [TW-1:0]               csize_q, comps_q, points_q, best_q;
	logic [1:0]                  rootch_q;
	logic [apf_pkg::FIELD_W-1:0] comp_res_q, art_res_q, big_res_q;

	logic [TW-1:0]        n_eff, t_next, new_low;
	logic [NW-1:0]        a_idx, b_idx;
	logic                 adj_we, node_we, stk_we;
	logic [NW-1:0]        adj_waddr, adj_raddr, node_waddr, node_raddr, stk_waddr, stk_raddr;
	logic [MAX_NODES-1:0] adj_wdata, adj_rdata;
	logic [NODE_W-1:0]    node_rdata;
	node_t                node_wr, node_rd;
	logic [TW-1:0]        stk_wdata, stk_rdata;

	assign n_eff = (32'(node_count_q) > 32'(MAX_NODES)) ? TW'(MAX_NODES) : TW'(node_count_q);
	assign t_next = timer_q + TW'(1);
	assign a_idx = NW'(a_q - 7'd1);
	assign b_idx = NW'(b_q - 7'd1);
	assign node_rd = node_t'(node_rdata);
	assign new_low = (low_q < node_rd.low) ? low_q : node_rd.low;

	assign status.clr_last = (k_q == LAST_IDX);
	assign status.run = in_mode;
	assign status.edge_ok = (in_node_a != '0) && (in_node_b != '0) && (in_node_a != in_node_b)
		&& (32'(in_node_a) <= 32'(n_eff)) && (32'(in_node_b) <= 32'(n_eff));
	assign status.outer_done = (i_q >= n_eff);
	assign status.rd_none = (node_rd.mark == apf_pkg::MARK_NONE);
	assign status.scan_end = (v_q >= n_eff);
	assign status.row_bit = row_q[NW'(v_q)];
	assign status.has_parent = pv_q;
	assign status.phase = phase_q;
	assign status.out_busy = res_valid_q;

	assign out_valid = res_valid_q;
	assign component_count = comp_res_q;
	assign articulation_count = art_res_q;
	assign biggest_remaining = big_res_q;

	// memory port steering
	always_comb begin
		adj_we = 1'b0;
		adj_waddr = '0;
		adj_wdata = '0;
		adj_raddr = '0;
		node_we = 1'b0;
		node_waddr = '0;
		node_wr = '0;
		node_raddr = '0;
		stk_we = 1'b0;
		stk_waddr = '0;
		stk_wdata = '0;
		stk_raddr = '0;
		case (op)
			apf_pkg::OP_CLR_ADJ: begin
				adj_we = 1'b1;
				adj_waddr = k_q;
			end
			apf_pkg::OP_EA_RD: adj_raddr = a_idx;
			apf_pkg::OP_EA_WR: begin
				adj_we = 1'b1;
				adj_waddr = a_idx;
				adj_wdata = adj_rdata | (ONE_HOT0 << b_idx);
			end
			apf_pkg::OP_EB_RD: adj_raddr = b_idx;
			apf_pkg::OP_EB_WR: begin
				adj_we = 1'b1;
				adj_waddr = b_idx;
				adj_wdata = adj_rdata | (ONE_HOT0 << a_idx);
			end
			apf_pkg::OP_NCLR: begin
				node_we = 1'b1;
				node_waddr = k_q;
				node_wr.mark = (phase_q && flags_q[k_q]) ? apf_pkg::MARK_GONE
					: apf_pkg::MARK_NONE;
			end
			apf_pkg::OP_ARD: adj_raddr = k_q;
			apf_pkg::OP_AWR: begin
				adj_we = 1'b1;
				adj_waddr = k_q;
				adj_wdata = flags_q[k_q] ? '0 : (adj_rdata & ~flags_q);
			end
			apf_pkg::OP_OUTER_RD: begin
				node_raddr = NW'(i_q);
				adj_raddr = NW'(i_q);
			end
			apf_pkg::OP_ROOT: begin
				node_we = 1'b1;
				node_waddr = NW'(i_q);
				node_wr.mark = apf_pkg::MARK_SEEN;
				node_wr.disc = t_next;
				node_wr.low = t_next;
			end
			apf_pkg::OP_SCAN_RD: node_raddr = NW'(v_q);
			apf_pkg::OP_PUSH1: begin
				node_we = 1'b1;
				node_waddr = u_q;
				node_wr.mark = apf_pkg::MARK_SEEN;
				node_wr.disc = disc_q;
				node_wr.low = low_q;
				node_wr.par = par_q;
				node_wr.pv = pv_q;
				stk_we = 1'b1;
				stk_waddr = depth_q;
				stk_wdata = v_q + TW'(1);
				adj_raddr = NW'(v_q);
			end
			apf_pkg::OP_PUSH2: begin
				node_we = 1'b1;
				node_waddr = NW'(v_q);
				node_wr.mark = apf_pkg::MARK_SEEN;
				node_wr.disc = t_next;
				node_wr.low = t_next;
				node_wr.par = u_q;
				node_wr.pv = 1'b1;
			end
			apf_pkg::OP_POP_RD: begin
				node_raddr = par_q;
				adj_raddr = par_q;
				stk_raddr = depth_q - NW'(1);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= apf_pkg::NODE_COUNT_RESET;
			a_q <= '0;
			b_q <= '0;
			k_q <= '0;
			u_q <= '0;
			root_q <= '0;
			par_q <= '0;
			depth_q <= '0;
			phase_q <= 1'b0;
			pv_q <= 1'b0;
			res_valid_q <= 1'b0;
			flags_q <= '0;
			row_q <= '0;
			i_q <= '0;
			v_q <= '0;
			timer_q <= '0;
			disc_q <= '0;
			low_q <= '0;
			csize_q <= '0;
			comps_q <= '0;
			points_q <= '0;
			best_q <= '0;
			rootch_q <= '0;
			comp_res_q <= '0;
			art_res_q <= '0;
			big_res_q <= '0;
		end else begin
			if (cfg_wen) begin
				node_count_q <= cfg_wdata;
			end
			if (res_valid_q && out_ready) begin
				res_valid_q <= 1'b0;
			end
			case (op)
				apf_pkg::OP_CLR_ADJ, apf_pkg::OP_AWR: begin
					k_q <= status.clr_last ? '0 : k_q + NW'(1);
				end
				apf_pkg::OP_ACCEPT: begin
					a_q <= in_node_a;
					b_q <= in_node_b;
					if (in_mode) begin
						flags_q <= '0;
						phase_q <= 1'b0;
						k_q <= '0;
						comps_q <= '0;
						points_q <= '0;
						best_q <= '0;
					end
				end
				apf_pkg::OP_NCLR: begin
					if (phase_q && flags_q[k_q]) begin
						points_q <= points_q + TW'(1);
					end
					k_q <= status.clr_last ? '0 : k_q + NW'(1);
				end
				apf_pkg::OP_OINIT: begin
					i_q <= '0;
					timer_q <= '0;
				end
				apf_pkg::OP_OUTER_NEXT: i_q <= i_q + TW'(1);
				apf_pkg::OP_ROOT: begin
					timer_q <= t_next;
					u_q <= NW'(i_q);
					root_q <= NW'(i_q);
					disc_q <= t_next;
					low_q <= t_next;
					pv_q <= 1'b0;
					depth_q <= '0;
					csize_q <= TW'(1);
					rootch_q <= '0;
					row_q <= adj_rdata;
					v_q <= '0;
				end
				apf_pkg::OP_SKIP: v_q <= v_q + TW'(1);
				apf_pkg::OP_PUSH1: begin
					if (u_q == root_q && rootch_q != 2'd2) begin
						rootch_q <= rootch_q + 2'd1;
					end
				end
				apf_pkg::OP_PUSH2: begin
					timer_q <= t_next;
					par_q <= u_q;
					pv_q <= 1'b1;
					u_q <= NW'(v_q);
					disc_q <= t_next;
					low_q <= t_next;
					row_q <= adj_rdata;
					v_q <= '0;
					depth_q <= depth_q + NW'(1);
					csize_q <= csize_q + TW'(1);
				end
				apf_pkg::OP_BACK: begin
					// back edge to a visited node other than the tree parent
					if (node_rd.mark != apf_pkg::MARK_GONE && !(pv_q && par_q == NW'(v_q))
						&& node_rd.disc < low_q) begin
						low_q <= node_rd.disc;
					end
					v_q <= v_q + TW'(1);
				end
				apf_pkg::OP_POP2: begin
					if (!phase_q && node_rd.pv && low_q >= node_rd.disc) begin
						flags_q[par_q] <= 1'b1;
					end
					u_q <= par_q;
					disc_q <= node_rd.disc;
					low_q <= new_low;
					par_q <= node_rd.par;
					pv_q <= node_rd.pv;
					v_q <= stk_rdata;
					row_q <= adj_rdata;
					depth_q <= depth_q - NW'(1);
				end
				apf_pkg::OP_WALK_END: begin
					if (!phase_q) begin
						comps_q <= comps_q + TW'(1);
						if (rootch_q == 2'd2) begin
							flags_q[root_q] <= 1'b1;
						end
					end else if (csize_q > best_q) begin
						best_q <= csize_q;
					end
					i_q <= i_q + TW'(1);
				end
				apf_pkg::OP_PHASE2: begin
					phase_q <= 1'b1;
					k_q <= '0;
				end
				apf_pkg::OP_LOAD_OUT: begin
					comp_res_q <= apf_pkg::FIELD_W'(comps_q);
					art_res_q <= apf_pkg::FIELD_W'(points_q);
					big_res_q <= apf_pkg::FIELD_W'(best_q);
					res_valid_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	apf_ram #(.WIDTH(MAX_NODES), .DEPTH(MAX_NODES)) u_adj_ram (
		.clk(clk), .we(adj_we), .waddr(adj_waddr), .wdata(adj_wdata),
		.raddr(adj_raddr), .rdata(adj_rdata)
	);

	apf_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_node_ram (
		.clk(clk), .we(node_we), .waddr(node_waddr), .wdata(NODE_W'(node_wr)),
		.raddr(node_raddr), .rdata(node_rdata)
	);

	apf_ram #(.WIDTH(TW), .DEPTH(MAX_NODES)) u_stack_ram (
		.clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
		.raddr(stk_raddr), .rdata(stk_rdata)
	);
endmodule

>>> src/apf_ctrl.sv
// controller state machine sequencing loads, sweeps and depth-first walks
module apf_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  apf_pkg::dp_status_t status,
	output apf_pkg::dp_op_t     op
);
	typedef enum logic [4:0] {
		S_CLR, S_IDLE, S_EA_RD, S_EA_WR, S_EB_RD, S_EB_WR, S_NCLR, S_ARD, S_AWR,
		S_OINIT, S_OUTER, S_OCHK, S_SCAN, S_CHECK, S_PUSH2, S_POP2, S_DONE
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		op = apf_pkg::OP_NONE;
		case (state_q)
			S_CLR: begin
				op = apf_pkg::OP_CLR_ADJ;
				if (status.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					op = apf_pkg::OP_ACCEPT;
					if (status.run) state_d = S_NCLR;
					else if (status.edge_ok) state_d = S_EA_RD;
				end
			end
			S_EA_RD: begin
				op = apf_pkg::OP_EA_RD;
				state_d = S_EA_WR;
			end
			S_EA_WR: begin
				op = apf_pkg::OP_EA_WR;
				state_d = S_EB_RD;
			end
			S_EB_RD: begin
				op = apf_pkg::OP_EB_RD;
				state_d = S_EB_WR;
			end
			S_EB_WR: begin
				op = apf_pkg::OP_EB_WR;
				state_d = S_IDLE;
			end
			S_NCLR: begin
				op = apf_pkg::OP_NCLR;
				if (status.clr_last) state_d = status.phase ? S_ARD : S_OINIT;
			end
			S_ARD: begin
				op = apf_pkg::OP_ARD;
				state_d = S_AWR;
			end
			S_AWR: begin
				op = apf_pkg::OP_AWR;
				state_d = status.clr_last ? S_OINIT : S_ARD;
			end
			S_OINIT: begin
				op = apf_pkg::OP_OINIT;
				state_d = S_OUTER;
			end
			S_OUTER: begin
				if (status.outer_done) begin
					if (status.phase) begin
						state_d = S_DONE;
					end else begin
						op = apf_pkg::OP_PHASE2;
						state_d = S_NCLR;
					end
				end else begin
					op = apf_pkg::OP_OUTER_RD;
					state_d = S_OCHK;
				end
			end
			S_OCHK: begin
				if (status.rd_none) begin
					op = apf_pkg::OP_ROOT;
					state_d = S_SCAN;
				end else begin
					op = apf_pkg::OP_OUTER_NEXT;
					state_d = S_OUTER;
				end
			end
			S_SCAN: begin
				if (status.scan_end) begin
					if (status.has_parent) begin
						op = apf_pkg::OP_POP_RD;
						state_d = S_POP2;
					end else begin
						op = apf_pkg::OP_WALK_END;
						state_d = S_OUTER;
					end
				end else if (status.row_bit) begin
					op = apf_pkg::OP_SCAN_RD;
					state_d = S_CHECK;
				end else begin
					op = apf_pkg::OP_SKIP;
				end
			end
			S_CHECK: begin
				if (status.rd_none) begin
					op = apf_pkg::OP_PUSH1;
					state_d = S_PUSH2;
				end else begin
					op = apf_pkg::OP_BACK;
					state_d = S_SCAN;
				end
			end
			S_PUSH2: begin
				op = apf_pkg::OP_PUSH2;
				state_d = S_SCAN;
			end
			S_POP2: begin
				op = apf_pkg::OP_POP2;
				state_d = S_SCAN;
			end
			S_DONE: begin
				if (!status.out_busy) begin
					op = apf_pkg::OP_LOAD_OUT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

>>> src/articulation_point_finder.sv
// top level of the articulation point finder
//
// in_ch carries items: mode 0 adds the undirected edge node_a-node_b (one-based),
// mode 1 runs the analysis. out_ch carries one summary transfer per run:
// component_count, articulation_count and biggest_remaining. node_count is
// written through cfg_wen/cfg_wdata; the user must write it only while the
// block is idle, which the block itself does not enforce. an edge item is a
// transfer, then a read-modify-write of each of the two adjacency rows through
// the adjacency ram's single write port; a bad edge is the transfer alone.
// a run clears the node table before each of the two walks and cleans up the
// adjacency rows, each read then written, between them. each walk scans the
// row of each active node one position per cycle where no neighbor is present;
// a present neighbor is first read through the node ram's single read port.
// after reset the adjacency ram is cleared one row a cycle with in_ch.ready low.
// results sit in an output register; a stalled receiver does not block edge
// loads, only the end of the next run, which waits for that register to empty.
module articulation_point_finder #(
	parameter int MAX_NODES = apf_pkg::APF_MAX_NODES
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wen,
	input  logic [apf_pkg::FIELD_W-1:0] cfg_wdata,
	apf_in_if.sink                      in_ch,
	apf_out_if.source                   out_ch
);
	apf_pkg::dp_op_t     op;
	apf_pkg::dp_status_t status;

	// sequencer: owns in_ch.ready, steps the datapath one command a cycle
	apf_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_ch.valid),
		.in_ready(in_ch.ready),
		.status(status),
		.op(op)
	);

	// memories, walk registers and the result register
	apf_datapath #(.MAX_NODES(MAX_NODES)) u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_wdata(cfg_wdata),
		.in_mode(in_ch.mode),
		.in_node_a(in_ch.node_a),
		.in_node_b(in_ch.node_b),
		.op(op),
		.status(status),
		.out_ready(out_ch.ready),
		.out_valid(out_ch.valid),
		.component_count(out_ch.component_count),
		.articulation_count(out_ch.articulation_count),
		.biggest_remaining(out_ch.biggest_remaining)
	);
endmodule

>>> src/apf_checker.sv
// port level checks of the articulation point finder, bound to the top level
module apf_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        in_mode,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [apf_pkg::FIELD_W-1:0] component_count,
	input logic [apf_pkg::FIELD_W-1:0] articulation_count,
	input logic [apf_pkg::FIELD_W-1:0] biggest_remaining
);
	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(component_count)
			&& $stable(articulation_count) && $stable(biggest_remaining))
		else $error("result changed while stalled");

	// a run transfer stops intake while the walks run
	a_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_mode |=> !in_ready)
		else $error("intake open right after a run transfer");

	// a result appears only at the end of a run, never while idle
	a_result_from_run: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result raised while idle");
endmodule

bind articulation_point_finder apf_checker u_apf_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_ch.valid),
	.in_ready(in_ch.ready),
	.in_mode(in_ch.mode),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.component_count(out_ch.component_count),
	.articulation_count(out_ch.articulation_count),
	.biggest_remaining(out_ch.biggest_remaining)
);

>>> sim/tb_top.sv
// self-checking testbench for articulation_point_finder: edge loads, runs and node count changes
`timescale 1ns / 1ps

module tb_top;
	localparam int NMAX = apf_pkg::APF_MAX_NODES;
	localparam int FW = apf_pkg::FIELD_W;
	localparam int NONE_PARENT = apf_pkg::APF_MAX_NODES;
	localparam int IDLE_PCT = 34;
	localparam int HOLD_CYCLES = 3000;
	localparam int SETTLE_CYCLES = 60;
	localparam longint CYCLE_LIMIT = 4_000_000;

	localparam bit MODE_EDGE = 1'b0;
	localparam bit MODE_RUN = 1'b1;

	typedef struct {
		bit           mode;
		bit [FW-1:0] a;
		bit [FW-1:0] b;
	} edge_item_t;

	typedef struct {
		bit [FW-1:0] comps;
		bit [FW-1:0] points;
		bit [FW-1:0] biggest;
	} summary_t;

	logic clk;
	logic arst_n;
	logic cfg_wen;
	logic [FW-1:0] cfg_wdata;

	apf_in_if in_ch ();
	apf_out_if out_ch ();

	articulation_point_finder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch.sink),
		.out_ch    (out_ch.source)
	);

	// stimulus and expectation queues
	edge_item_t pending_items[$];
	summary_t   expected_summaries[$];

	int  errors;
	bit  idle_en;
	bit  hold_req;
	int  hold_cnt;
	longint cycles;

	// graph shadow: adjacency, node count and walk scratch
	bit [NMAX-1:0] adj [NMAX];
	int    node_cnt;
	apf_pkg::mark_t mark [NMAX];
	int    disc [NMAX];
	int    low [NMAX];
	int    par [NMAX];
	bit    cut_flag [NMAX];
	int    stk [NMAX];
	int    nxt [NMAX];
	int    timer;
	int    root_ch;
	int    comp_sz;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic void reset_walk();
		timer = 0;
		for (int i = 0; i < NMAX; i++) begin
			mark[i] = apf_pkg::MARK_NONE;
			disc[i] = 0;
			low[i] = 0;
			par[i] = NONE_PARENT;
		end
	endfunction

	function automatic void visit_node(int v, int depth);
		timer++;
		disc[v] = timer;
		low[v] = timer;
		mark[v] = apf_pkg::MARK_SEEN;
		comp_sz++;
		stk[depth] = v;
		nxt[depth] = 0;
	endfunction

	// iterative dfs with discovery/low times; optionally flags cut vertices
	function automatic void graph_walk(int root, int n, bit flag_pts);
		int sp;
		int u;
		int v;
		int p;
		bit pushed;
		sp = 1;
		root_ch = 0;
		comp_sz = 0;
		par[root] = NONE_PARENT;
		visit_node(root, 0);
		while (sp > 0) begin
			u = stk[sp-1];
			v = nxt[sp-1];
			pushed = 0;
			while (v < n && !pushed) begin
				if (adj[u][v] && mark[v] != apf_pkg::MARK_GONE) begin
					if (mark[v] == apf_pkg::MARK_NONE) begin
						if (u == root)
							root_ch++;
						par[v] = u;
						nxt[sp-1] = v + 1;
						visit_node(v, sp);
						sp++;
						pushed = 1;
					end else if (v != par[u] && disc[v] < low[u]) begin
						low[u] = disc[v];
					end
				end
				v++;
			end
			if (!pushed) begin
				sp--;
				if (par[u] < NMAX) begin
					p = par[u];
					if (low[u] < low[p])
						low[p] = low[u];
					// non-root parent cut when the child cannot reach above it
					if (flag_pts && par[p] != NONE_PARENT && low[u] >= disc[p])
						cut_flag[p] = 1;
				end
			end
		end
		// root is a cut vertex only with two or more tree children
		if (flag_pts && root_ch > 1)
			cut_flag[root] = 1;
	endfunction

	function automatic summary_t analyze_graph();
		summary_t s;
		int n;
		int comps;
		int points;
		int best;
		n = (node_cnt > NMAX) ? NMAX : node_cnt;
		comps = 0;
		points = 0;
		best = 0;
		reset_walk();
		for (int i = 0; i < NMAX; i++)
			cut_flag[i] = 0;
		for (int i = 0; i < n; i++) begin
			if (mark[i] == apf_pkg::MARK_NONE) begin
				graph_walk(i, n, 1'b1);
				comps++;
			end
		end
		// cut vertices lose every edge for good, even in later runs
		reset_walk();
		for (int i = 0; i < n; i++) begin
			if (cut_flag[i]) begin
				points++;
				adj[i] = '0;
				for (int j = 0; j < NMAX; j++)
					adj[j][i] = 1'b0;
				mark[i] = apf_pkg::MARK_GONE;
			end
		end
		for (int i = 0; i < n; i++) begin
			if (mark[i] == apf_pkg::MARK_NONE) begin
				graph_walk(i, n, 1'b0);
				if (comp_sz > best)
					best = comp_sz;
			end
		end
		s.comps = comps[FW-1:0];
		s.points = points[FW-1:0];
		s.biggest = best[FW-1:0];
		return s;
	endfunction

	function automatic void apply_item(bit mode, int a, int b);
		int n;
		n = (node_cnt > NMAX) ? NMAX : node_cnt;
		if (mode == MODE_RUN) begin
			expected_summaries.push_back(analyze_graph());
		end else if (a >= 1 && a <= n && b >= 1 && b <= n && a != b) begin
			// self loops and out-of-range endpoints are dropped
			adj[a-1][b-1] = 1'b1;
			adj[b-1][a-1] = 1'b1;
		end
	endfunction

	// driver: predicts on each accepted transfer, then offers the next item
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready)
				apply_item(in_ch.mode, in_ch.node_a, in_ch.node_b);
			if (!in_ch.valid || in_ch.ready) begin
				if (pending_items.size() > 0 &&
					!(idle_en && $urandom_range(99) < IDLE_PCT)) begin
					edge_item_t it;
					it = pending_items.pop_front();
					in_ch.valid <= 1'b1;
					in_ch.mode <= it.mode;
					in_ch.node_a <= it.a;
					in_ch.node_b <= it.b;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// receiver ready, with random stalls and one long hold-off
	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_req) begin
				hold_req = 0;
				hold_cnt = HOLD_CYCLES;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= !(idle_en && $urandom_range(99) < IDLE_PCT);
			end
		end
	end

	// monitor: compare each summary transfer with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_summaries.size() == 0) begin
				errors++;
				$display("%0t: unexpected summary comps=%0d points=%0d biggest=%0d", $time,
					out_ch.component_count, out_ch.articulation_count,
					out_ch.biggest_remaining);
			end else begin
				summary_t e;
				e = expected_summaries.pop_front();
				if (out_ch.component_count !== e.comps) begin
					errors++;
					$display("%0t: component_count expected %0d actual %0d", $time,
						e.comps, out_ch.component_count);
				end
				if (out_ch.articulation_count !== e.points) begin
					errors++;
					$display("%0t: articulation_count expected %0d actual %0d", $time,
						e.points, out_ch.articulation_count);
				end
				if (out_ch.biggest_remaining !== e.biggest) begin
					errors++;
					$display("%0t: biggest_remaining expected %0d actual %0d", $time,
						e.biggest, out_ch.biggest_remaining);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic queue_item(bit mode, int a, int b);
		edge_item_t it;
		it.mode = mode;
		it.a = a[FW-1:0];
		it.b = b[FW-1:0];
		pending_items.push_back(it);
	endtask

	// mostly valid edges inside the active range, some runs, some junk
	task automatic queue_random(int count, int run_pct, int nc);
		int eff;
		int r;
		eff = (nc > NMAX) ? NMAX : nc;
		for (int k = 0; k < count; k++) begin
			r = $urandom_range(99);
			if (r < run_pct)
				queue_item(MODE_RUN, $urandom_range(127), $urandom_range(127));
			else if (r < 88 && eff >= 1)
				queue_item(MODE_EDGE, $urandom_range(eff, 1), $urandom_range(eff, 1));
			else
				queue_item(MODE_EDGE, $urandom_range(127), $urandom_range(127));
		end
		queue_item(MODE_RUN, $urandom_range(127), $urandom_range(127));
	endtask

	// block is idle once everything is sent and every summary has come back
	task automatic wait_drained();
		while (pending_items.size() > 0 || in_ch.valid || expected_summaries.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_node_count(int value);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= value[FW-1:0];
		@(posedge clk);
		cfg_wen <= 1'b0;
		node_cnt = value & 7'h7f;
	endtask

	int phase_nc [14] = '{8, 1, 0, 127, 12, 3, 20, 2, 16, 5, 64, 10, 30, 6};

	initial begin
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_wdata = '0;
		in_ch.valid = 1'b0;
		in_ch.mode = 1'b0;
		in_ch.node_a = '0;
		in_ch.node_b = '0;
		out_ch.ready = 1'b0;
		errors = 0;
		cycles = 0;
		idle_en = 1;
		hold_req = 0;
		hold_cnt = 0;
		node_cnt = apf_pkg::NODE_COUNT_RESET;
		for (int i = 0; i < NMAX; i++)
			adj[i] = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed: range ends, duplicates, self loop, zero and oversize endpoints
		queue_item(MODE_EDGE, 1, 64);
		queue_item(MODE_EDGE, 64, 1);
		queue_item(MODE_EDGE, 5, 5);
		queue_item(MODE_EDGE, 0, 3);
		queue_item(MODE_EDGE, 3, 0);
		queue_item(MODE_EDGE, 65, 2);
		queue_item(MODE_EDGE, 127, 127);
		queue_item(MODE_RUN, 0, 0);
		// path 64-1-2-3-4: three inner cut vertices
		queue_item(MODE_EDGE, 1, 2);
		queue_item(MODE_EDGE, 2, 3);
		queue_item(MODE_EDGE, 3, 4);
		queue_item(MODE_RUN, 127, 127);
		// removed vertices stay isolated on the next run
		queue_item(MODE_RUN, 85, 42);
		// star around 10, plus a triangle with no cut vertex
		queue_item(MODE_EDGE, 10, 11);
		queue_item(MODE_EDGE, 10, 12);
		queue_item(MODE_EDGE, 13, 10);
		queue_item(MODE_EDGE, 20, 21);
		queue_item(MODE_EDGE, 21, 22);
		queue_item(MODE_EDGE, 22, 20);
		queue_item(MODE_RUN, 1, 64);
		queue_random(50, 3, 64);
		wait_drained();

		foreach (phase_nc[p]) begin
			write_node_count(phase_nc[p]);
			// no idling in one phase; long receiver hold-off in another
			idle_en = (p != 3);
			if (p == 2)
				hold_req = 1;
			if (phase_nc[p] >= NMAX)
				queue_random(70, 3, phase_nc[p]);
			else
				queue_random(120, 7, phase_nc[p]);
			wait_drained();
		end

		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
